[sv/maxrects_bssf_packer_defines.svh]
// assertion macros shared by the checker
`ifndef MAXRECTS_BSSF_PACKER_DEFINES_SVH
`define MAXRECTS_BSSF_PACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mrb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_pkg
// Shared types and constants of the maxrects best-short-side-fit packer.
// ----------------------------------------------------------------------------
package mrb_pkg;

  localparam int FIELD_W   = 14;  // patch and bin size fields
  localparam int ALIGN_W   = 7;
  localparam int POS_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int SIZE_W    = 15;  // aligned patch size
  localparam int DIV_STEPS = 15;
  localparam int DCNT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT  = 2'd2;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_PLACE   = 1'b1;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_RESTART,
    ST_DIV,
    ST_MUL,
    ST_SCAN_RD,
    ST_SCAN_EV,
    ST_PICK,
    ST_SEL_RD,
    ST_SEL_EV,
    ST_UNT_RD,
    ST_UNT_EV,
    ST_REM_TOP,
    ST_REM_RIGHT,
    ST_CRV_RD,
    ST_CRV_EV,
    ST_CRV_PC,
    ST_PR_START,
    ST_PR_IRD,
    ST_PR_ILAT,
    ST_PR_JRD,
    ST_PR_JEV,
    ST_PR_WR,
    ST_OUT_ZERO,
    ST_OUT_FIT
  } mrb_state_t;

  typedef struct packed {
    logic in_ready;
    logic restart;
    logic div_step;
    logic mul;
    logic tbl_rd_best;
    logic scan_ev;
    logic sel_ev;
    logic unt_ev;
    logic rem_top;
    logic rem_right;
    logic crv_ev;
    logic crv_pc;
    logic pr_start;
    logic wrk_rd_j;
    logic pr_ilat;
    logic pr_jev;
    logic pr_wr;
    logic out_zero;
    logic out_fit;
  } mrb_cmd_t;

  typedef struct packed {
    logic in_acc;
    logic in_place;
    logic div_done;
    logic tbl_empty;
    logic found;
    logic i_last;
    logic k_last;
    logic wrk_empty;
    logic pi_last;
    logic j_last;
    logic res_free;
  } mrb_stat_t;

endpackage

[sv/mrb_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_if
// Patch request, placement result and register write channels.
// ----------------------------------------------------------------------------
interface mrb_item_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [mrb_pkg::FIELD_W-1:0]  patch_width;
  logic [mrb_pkg::FIELD_W-1:0]  patch_height;
  logic                         no_rotate;

  modport source (output valid, command, patch_width, patch_height, no_rotate,
                  input ready);
  modport sink   (input valid, command, patch_width, patch_height, no_rotate,
                  output ready);
endinterface

interface mrb_result_if;
  logic                       valid;
  logic                       ready;
  logic                       placed;
  logic [mrb_pkg::POS_W-1:0]  pos_x;
  logic [mrb_pkg::POS_W-1:0]  pos_y;
  logic                       rotated;
  logic                       overflow;

  modport source (output valid, placed, pos_x, pos_y, rotated, overflow, input ready);
  modport sink   (input valid, placed, pos_x, pos_y, rotated, overflow, output ready);
endinterface

interface mrb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mrb_pkg::CFG_IDX_W-1:0]  index;
  logic [mrb_pkg::FIELD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/mrb_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_ctrl
// Sequencer of the packer: steps the datapath through align, scan, split,
// carve and prune for each placement.
// ----------------------------------------------------------------------------
module mrb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  mrb_pkg::mrb_stat_t stat,
  output mrb_pkg::mrb_cmd_t  cmd
);
  import mrb_pkg::*;

  mrb_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:      state_next = ST_IDLE;
      ST_IDLE: begin
        if (stat.in_acc) begin
          state_next = stat.in_place ? ST_DIV : ST_RESTART;
        end
      end
      ST_RESTART:   state_next = ST_OUT_ZERO;
      ST_DIV: begin
        if (stat.div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:       state_next = stat.tbl_empty ? ST_OUT_ZERO : ST_SCAN_RD;
      ST_SCAN_RD:   state_next = ST_SCAN_EV;
      ST_SCAN_EV:   state_next = stat.i_last ? ST_PICK : ST_SCAN_RD;
      ST_PICK:      state_next = stat.found ? ST_SEL_RD : ST_OUT_ZERO;
      ST_SEL_RD:    state_next = ST_SEL_EV;
      ST_SEL_EV:    state_next = ST_UNT_RD;
      ST_UNT_RD:    state_next = ST_UNT_EV;
      ST_UNT_EV:    state_next = stat.i_last ? ST_REM_TOP : ST_UNT_RD;
      ST_REM_TOP:   state_next = ST_REM_RIGHT;
      ST_REM_RIGHT: state_next = ST_CRV_RD;
      ST_CRV_RD:    state_next = ST_CRV_EV;
      ST_CRV_EV:    state_next = ST_CRV_PC;
      ST_CRV_PC: begin
        if (stat.k_last) begin
          state_next = stat.i_last ? ST_PR_START : ST_CRV_RD;
        end
      end
      ST_PR_START:  state_next = stat.wrk_empty ? ST_OUT_FIT : ST_PR_IRD;
      ST_PR_IRD:    state_next = ST_PR_ILAT;
      ST_PR_ILAT:   state_next = ST_PR_JRD;
      ST_PR_JRD:    state_next = ST_PR_JEV;
      ST_PR_JEV:    state_next = stat.j_last ? ST_PR_WR : ST_PR_JRD;
      ST_PR_WR:     state_next = stat.pi_last ? ST_OUT_FIT : ST_PR_IRD;
      ST_OUT_ZERO, ST_OUT_FIT: begin
        if (stat.res_free) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_INIT, ST_RESTART: cmd.restart = 1'b1;
      ST_IDLE:      cmd.in_ready    = 1'b1;
      ST_DIV:       cmd.div_step    = 1'b1;
      ST_MUL:       cmd.mul         = 1'b1;
      ST_SCAN_EV:   cmd.scan_ev     = 1'b1;
      ST_SEL_RD:    cmd.tbl_rd_best = 1'b1;
      ST_SEL_EV:    cmd.sel_ev      = 1'b1;
      ST_UNT_EV:    cmd.unt_ev      = 1'b1;
      ST_REM_TOP:   cmd.rem_top     = 1'b1;
      ST_REM_RIGHT: cmd.rem_right   = 1'b1;
      ST_CRV_EV:    cmd.crv_ev      = 1'b1;
      ST_CRV_PC:    cmd.crv_pc      = 1'b1;
      ST_PR_START:  cmd.pr_start    = 1'b1;
      ST_PR_ILAT:   cmd.pr_ilat     = 1'b1;
      ST_PR_JRD:    cmd.wrk_rd_j    = 1'b1;
      ST_PR_JEV:    cmd.pr_jev      = 1'b1;
      ST_PR_WR:     cmd.pr_wr       = 1'b1;
      ST_OUT_ZERO:  cmd.out_zero    = stat.res_free;
      ST_OUT_FIT:   cmd.out_fit     = stat.res_free;
      default:      cmd = '0;
    endcase
  end

endmodule

[sv/mrb_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_datapath
// Free rectangle table, work table, aligner, fit scoring, carving and
// containment logic, configuration registers and result register.
// ----------------------------------------------------------------------------
module mrb_datapath #(
  parameter int MAX_FREE_RECTS = 256,
  parameter int COORD_BITS     = 13
) (
  input  logic               clk,
  input  logic               rst,
  mrb_item_if.sink           item,
  mrb_result_if.source       result,
  mrb_cfg_if.sink            cfg,
  input  mrb_pkg::mrb_cmd_t  cmd,
  output mrb_pkg::mrb_stat_t stat
);
  import mrb_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int IW = (MAX_FREE_RECTS > 1) ? $clog2(MAX_FREE_RECTS) : 1;
  localparam int CW = $clog2(MAX_FREE_RECTS + 1);
  localparam int EW = (CB + 2 > SIZE_W + 1) ? CB + 2 : SIZE_W + 1;
  localparam int SW = CB + 1;
  localparam int DW = (CB + 1 > FIELD_W) ? CB + 1 : FIELD_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FREE_RECTS);
  localparam logic [SW-1:0] SCORE_NONE = {SW{1'b1}};

  typedef struct packed {
    logic [CB-1:0] x0;
    logic [CB-1:0] y0;
    logic [CB-1:0] x1;
    logic [CB-1:0] y1;
  } rect_t;

  function automatic logic [CB-1:0] clamp_last(input logic [FIELD_W-1:0] v);
    logic [DW-1:0] ve;
    logic [DW-1:0] lim;
    ve  = DW'(v);
    lim = DW'(1) << CB;
    if (ve == '0) begin
      return '0;
    end else if (ve > lim) begin
      return {CB{1'b1}};
    end
    return CB'(ve - DW'(1));
  endfunction

  function automatic logic [SW-1:0] fit_score(input rect_t r, input logic [SIZE_W-1:0] ww,
                                              input logic [SIZE_W-1:0] hh);
    logic [EW-1:0] rw;
    logic [EW-1:0] rh;
    logic [EW-1:0] dx;
    logic [EW-1:0] dy;
    rw = EW'(r.x1) - EW'(r.x0) + EW'(1);
    rh = EW'(r.y1) - EW'(r.y0) + EW'(1);
    dx = rw - EW'(ww);
    dy = rh - EW'(hh);
    if (EW'(ww) > rw || EW'(hh) > rh) begin
      return SCORE_NONE;
    end
    return (dx < dy) ? SW'(dx) : SW'(dy);
  endfunction

  function automatic logic overlaps(input rect_t a, input rect_t f);
    return a.x1 >= f.x0 && f.x1 >= a.x0 && a.y1 >= f.y0 && f.y1 >= a.y0;
  endfunction

  // configuration registers
  logic [FIELD_W-1:0] bin_w;
  logic [FIELD_W-1:0] bin_h;
  logic [ALIGN_W-1:0] align;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_w <= FIELD_W'(4096);
      bin_h <= FIELD_W'(4096);
      align <= ALIGN_W'(8);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_BIN_WIDTH:  bin_w <= cfg.data;
        CFG_BIN_HEIGHT: bin_h <= cfg.data;
        CFG_ALIGNMENT:  align <= cfg.data[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  rect_t tbl_mem [MAX_FREE_RECTS];
  rect_t wrk_mem [MAX_FREE_RECTS];
  rect_t tbl_q, wrk_q;
  logic          tbl_we, wrk_we;
  logic [IW-1:0] tbl_waddr, tbl_raddr, wrk_raddr;
  rect_t         tbl_wdata, wrk_wdata;

  // control registers
  logic [CW-1:0]     cnt, n, i, j;
  logic [IW-1:0]     best;
  logic [SW-1:0]     low_score;
  logic              best_rot, found, ovf, drop, hit, no_rot;
  logic [1:0]        k;
  logic [DCNT_W-1:0] dcnt;
  logic              res_valid;

  // payload registers
  logic [ALIGN_W-1:0] a_reg;
  logic [SIZE_W-1:0]  sh_w, sh_h, w, h;
  logic [ALIGN_W-1:0] rem_w, rem_h;
  rect_t              sel, fr, pa;
  logic               res_placed, res_rot, res_ovf;
  logic [POS_W-1:0]   res_x, res_y;

  logic               in_acc;
  logic [ALIGN_W-1:0] a_eff;
  logic [SIZE_W-1:0]  vw, vh;
  logic [ALIGN_W:0]   rs_w, rs_h;
  logic               ge_w, ge_h;
  logic [SW-1:0]      s_reg, s_rot;
  logic [SIZE_W-1:0]  bw, bh;
  logic [EW-1:0]      sel_rw, sel_rh;
  rect_t              b, top_r, right_r, piece;
  logic               top_ok, right_ok, piece_ok, put, unt_ok, right_blocked;
  logic               contained;

  assign in_acc     = item.valid && cmd.in_ready;
  assign item.ready = cmd.in_ready;
  assign a_eff      = (align == '0) ? ALIGN_W'(1) : align;
  assign vw = (item.patch_width  == '0) ? SIZE_W'(1) : SIZE_W'(item.patch_width);
  assign vh = (item.patch_height == '0) ? SIZE_W'(1) : SIZE_W'(item.patch_height);

  // restoring division step for round-up alignment
  assign rs_w = {rem_w, sh_w[SIZE_W-1]};
  assign rs_h = {rem_h, sh_h[SIZE_W-1]};
  assign ge_w = rs_w >= {1'b0, a_reg};
  assign ge_h = rs_h >= {1'b0, a_reg};

  assign s_reg = fit_score(tbl_q, w, h);
  assign s_rot = fit_score(tbl_q, h, w);

  // placed box and split remainders of the chosen rectangle
  always_comb begin
    bw     = best_rot ? h : w;
    bh     = best_rot ? w : h;
    sel_rw = EW'(sel.x1) - EW'(sel.x0) + EW'(1);
    sel_rh = EW'(sel.y1) - EW'(sel.y0) + EW'(1);
    b.x0   = sel.x0;
    b.y0   = sel.y0;
    b.x1   = CB'(EW'(sel.x0) + EW'(bw) - EW'(1));
    b.y1   = CB'(EW'(sel.y0) + EW'(bh) - EW'(1));
    top_ok   = EW'(bh) < sel_rh;
    right_ok = EW'(bw) < sel_rw;
    top_r      = sel;
    top_r.y0   = CB'(EW'(sel.y0) + EW'(bh));
    right_r    = sel;
    right_r.x0 = CB'(EW'(sel.x0) + EW'(bw));
    right_blocked = (cnt == MAX_CNT) && top_ok;
    unt_ok = (i[IW-1:0] != best) && !overlaps(b, tbl_q);
  end

  // carving pieces of an overlapped rectangle
  always_comb begin
    piece = fr;
    piece_ok = 1'b0;
    case (k)
      2'd0: begin
        piece_ok = fr.x0 < b.x0;
        piece.x1 = b.x0 - CB'(1);
      end
      2'd1: begin
        piece_ok = b.x1 < fr.x1;
        piece.x0 = b.x1 + CB'(1);
      end
      2'd2: begin
        piece_ok = fr.y0 < b.y0;
        piece.y1 = b.y0 - CB'(1);
      end
      2'd3: begin
        piece_ok = b.y1 < fr.y1;
        piece.y0 = b.y1 + CB'(1);
      end
      default: piece_ok = 1'b0;
    endcase
  end

  // work table write
  always_comb begin
    put       = 1'b0;
    wrk_wdata = tbl_q;
    if (cmd.unt_ev) begin
      put = unt_ok;
    end else if (cmd.rem_top) begin
      put       = top_ok;
      wrk_wdata = top_r;
    end else if (cmd.rem_right) begin
      put       = right_ok && !right_blocked;
      wrk_wdata = right_r;
    end else if (cmd.crv_pc) begin
      put       = hit && piece_ok;
      wrk_wdata = piece;
    end
    wrk_we = put && (n < MAX_CNT);
  end

  assign contained = (j != i) && wrk_q.x0 <= pa.x0 && pa.x1 <= wrk_q.x1 &&
                     wrk_q.y0 <= pa.y0 && pa.y1 <= wrk_q.y1 &&
                     !((wrk_q == pa) && (j > i));

  // free table write
  always_comb begin
    tbl_we    = cmd.restart || (cmd.pr_wr && !drop);
    tbl_waddr = cmd.restart ? '0 : cnt[IW-1:0];
    tbl_wdata = pa;
    if (cmd.restart) begin
      tbl_wdata.x0 = '0;
      tbl_wdata.y0 = '0;
      tbl_wdata.x1 = clamp_last(bin_w);
      tbl_wdata.y1 = clamp_last(bin_h);
    end
  end

  assign tbl_raddr = cmd.tbl_rd_best ? best : i[IW-1:0];
  assign wrk_raddr = cmd.wrk_rd_j ? j[IW-1:0] : i[IW-1:0];

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (wrk_we) begin
      wrk_mem[n[IW-1:0]] <= wrk_wdata;
    end
    wrk_q <= wrk_mem[wrk_raddr];
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      n <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
      dcnt <= '0;
      best <= '0;
      low_score <= SCORE_NONE;
      best_rot <= 1'b0;
      found <= 1'b0;
      ovf <= 1'b0;
      drop <= 1'b0;
      hit <= 1'b0;
      no_rot <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        no_rot <= item.no_rotate;
        dcnt   <= '0;
      end
      if (cmd.div_step) begin
        dcnt <= dcnt + DCNT_W'(1);
      end
      if (cmd.restart) begin
        cnt <= CW'(1);
      end
      if (cmd.mul) begin
        i <= '0;
        n <= '0;
        found <= 1'b0;
        ovf <= 1'b0;
        low_score <= SCORE_NONE;
        best_rot <= 1'b0;
      end
      if (cmd.scan_ev) begin
        if ((no_rot || s_reg <= s_rot) && s_reg < low_score) begin
          best <= i[IW-1:0];
          low_score <= s_reg;
          best_rot <= 1'b0;
          found <= 1'b1;
        end else if (!no_rot && s_rot < low_score) begin
          best <= i[IW-1:0];
          low_score <= s_rot;
          best_rot <= 1'b1;
          found <= 1'b1;
        end
        i <= i + CW'(1);
      end
      if (cmd.sel_ev || cmd.rem_right || cmd.pr_start) begin
        i <= '0;
      end
      if (cmd.unt_ev) begin
        i <= i + CW'(1);
      end
      if (put) begin
        if (n < MAX_CNT) begin
          n <= n + CW'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (cmd.rem_right && right_ok && right_blocked) begin
        ovf <= 1'b1;
      end
      if (cmd.crv_ev) begin
        hit <= (i[IW-1:0] != best) && overlaps(b, tbl_q);
        k <= '0;
      end
      if (cmd.crv_pc) begin
        k <= k + 2'd1;
        if (k == 2'd3) begin
          i <= i + CW'(1);
        end
      end
      if (cmd.pr_start) begin
        cnt <= '0;
      end
      if (cmd.pr_ilat) begin
        j <= '0;
        drop <= 1'b0;
      end
      if (cmd.pr_jev) begin
        if (contained) begin
          drop <= 1'b1;
        end
        j <= j + CW'(1);
      end
      if (cmd.pr_wr) begin
        if (!drop) begin
          cnt <= cnt + CW'(1);
        end
        i <= i + CW'(1);
      end
      if (cmd.out_zero || cmd.out_fit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_reg <= a_eff;
      sh_w  <= vw + SIZE_W'(a_eff) - SIZE_W'(1);
      sh_h  <= vh + SIZE_W'(a_eff) - SIZE_W'(1);
      rem_w <= '0;
      rem_h <= '0;
    end
    if (cmd.div_step) begin
      rem_w <= ge_w ? ALIGN_W'(rs_w - {1'b0, a_reg}) : rs_w[ALIGN_W-1:0];
      rem_h <= ge_h ? ALIGN_W'(rs_h - {1'b0, a_reg}) : rs_h[ALIGN_W-1:0];
      sh_w  <= {sh_w[SIZE_W-2:0], ge_w};
      sh_h  <= {sh_h[SIZE_W-2:0], ge_h};
    end
    if (cmd.mul) begin
      w <= SIZE_W'(sh_w * a_reg);
      h <= SIZE_W'(sh_h * a_reg);
    end
    if (cmd.sel_ev) begin
      sel <= tbl_q;
    end
    if (cmd.crv_ev) begin
      fr <= tbl_q;
    end
    if (cmd.pr_ilat) begin
      pa <= wrk_q;
    end
    if (cmd.out_zero) begin
      res_placed <= 1'b0;
      res_x      <= '0;
      res_y      <= '0;
      res_rot    <= 1'b0;
      res_ovf    <= 1'b0;
    end else if (cmd.out_fit) begin
      res_placed <= 1'b1;
      res_x      <= POS_W'(b.x0);
      res_y      <= POS_W'(b.y0);
      res_rot    <= best_rot;
      res_ovf    <= ovf;
    end
  end

  assign result.valid    = res_valid;
  assign result.placed   = res_placed;
  assign result.pos_x    = res_x;
  assign result.pos_y    = res_y;
  assign result.rotated  = res_rot;
  assign result.overflow = res_ovf;

  always_comb begin
    stat.in_acc    = in_acc;
    stat.in_place  = item.command == CMD_PLACE;
    stat.div_done  = dcnt == DCNT_W'(DIV_STEPS - 1);
    stat.tbl_empty = cnt == '0;
    stat.found     = found;
    stat.i_last    = i == cnt - CW'(1);
    stat.k_last    = k == 2'd3;
    stat.wrk_empty = n == '0;
    stat.pi_last   = i == n - CW'(1);
    stat.j_last    = j == n - CW'(1);
    stat.res_free  = !res_valid || result.ready;
  end

endmodule

[sv/maxrects_bssf_packer.sv]
`timescale 1ns / 1ps
// The containment prune compares each work-table candidate with every other candidate,
// reading the work table through a single read port. One item is worked on at a time;
// the next is taken once the result is in the output register. After reset the INIT
// state loads the whole bin before the first item is taken.
// ----------------------------------------------------------------------------
// maxrects_bssf_packer
// Rectangle packer using the maxrects best-short-side-fit rule.
// ----------------------------------------------------------------------------
module maxrects_bssf_packer #(
  parameter int MAX_FREE_RECTS = 256,
  parameter int COORD_BITS     = 13
) (
  input  logic         clk,
  input  logic         rst,
  mrb_item_if.sink     item,
  mrb_result_if.source result,
  mrb_cfg_if.sink      cfg
);
  import mrb_pkg::*;

  mrb_cmd_t  cmd;
  mrb_stat_t stat;

  mrb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  mrb_datapath #(
    .MAX_FREE_RECTS (MAX_FREE_RECTS),
    .COORD_BITS     (COORD_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule

[sv/mrb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrb_checker
// Port-level checks of the packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "maxrects_bssf_packer_defines.svh"

module mrb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      item_valid,
  input logic                      item_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      res_placed,
  input logic [mrb_pkg::POS_W-1:0] res_pos_x,
  input logic [mrb_pkg::POS_W-1:0] res_pos_y,
  input logic                      res_rotated,
  input logic                      res_overflow
);

  // one transaction in flight: request side closes right after taking one
  `MRB_ASSERT_NEXT(a_one_in_flight, item_valid && item_ready, !item_ready, "second request taken")

  `MRB_ASSERT_NOW(a_miss_is_zero, res_valid && !res_placed, (res_pos_x == '0) && (res_pos_y == '0) && !res_rotated && !res_overflow, "unplaced result not zero")

  `MRB_ASSERT_NOW(a_flags_need_place, res_valid && (res_rotated || res_overflow), res_placed, "flag without placement")

  `MRB_ASSERT_NEXT(a_result_held, res_valid && !res_ready, res_valid && $stable(res_pos_x) && $stable(res_pos_y) && $stable(res_placed), "stalled result changed")

endmodule

bind maxrects_bssf_packer mrb_checker u_mrb_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_placed   (result.placed),
  .res_pos_x    (result.pos_x),
  .res_pos_y    (result.pos_y),
  .res_rotated  (result.rotated),
  .res_overflow (result.overflow)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives patch placements and restarts into the packer and checks every
// placement result against a behavioral free-rectangle table kept here.
// ----------------------------------------------------------------------------
module tb_top;
  import mrb_pkg::*;

  localparam int TBL_DEPTH = 256;
  localparam int CBITS     = 13;
  localparam int STALL_LIMIT = 1000000;

  typedef struct {
    int unsigned x0, y0, x1, y1;
  } box_t;

  typedef struct packed {
    logic             placed;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             rotated;
    logic             overflow;
  } placement_t;

  logic clk;
  logic rst;

  mrb_item_if   item_ch ();
  mrb_result_if res_ch ();
  mrb_cfg_if    cfg_ch ();

  maxrects_bssf_packer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (res_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // packer model state
  box_t        free_tbl[TBL_DEPTH];
  int unsigned free_cnt;
  int unsigned bin_w, bin_h, align_q;

  placement_t  expected_placements[$];
  int          mismatches;
  int          timeouts;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          recv_hold;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned clamp_side(int unsigned v);
    if (v < 1) return 1;
    if (v > (1 << CBITS)) return 1 << CBITS;
    return v;
  endfunction

  function automatic void load_bin();
    free_tbl[0].x0 = 0;
    free_tbl[0].y0 = 0;
    free_tbl[0].x1 = clamp_side(bin_w) - 1;
    free_tbl[0].y1 = clamp_side(bin_h) - 1;
    free_cnt = 1;
  endfunction

  function automatic int unsigned short_side_left(box_t r, int unsigned w, int unsigned h);
    int unsigned rw, rh;
    rw = r.x1 - r.x0 + 1;
    rh = r.y1 - r.y0 + 1;
    if (w > rw || h > rh) return 32'hFFFF_FFFF;
    return (rw - w < rh - h) ? rw - w : rh - h;
  endfunction

  function automatic int unsigned round_up(int unsigned v, int unsigned a);
    if (v < 1) v = 1;
    return ((v + a - 1) / a) * a;
  endfunction

  function automatic bit covered_by(box_t a, box_t b);
    return b.x0 <= a.x0 && a.x1 <= b.x1 && b.y0 <= a.y0 && a.y1 <= b.y1;
  endfunction

  function automatic bit same_box(box_t a, box_t b);
    return a.x0 == b.x0 && a.y0 == b.y0 && a.x1 == b.x1 && a.y1 == b.y1;
  endfunction

  // expected outcome of one transaction; updates the table
  function automatic placement_t pack_patch(bit cmd, int unsigned pw, int unsigned ph,
                                            bit no_rot);
    placement_t  p;
    int unsigned a, w, h, best, best_sc, sr, st, bw, bh, n;
    bit          found, best_rot, ovf, hit;
    box_t        sel, pb, r, f;
    box_t        work[TBL_DEPTH];
    bit          drop[TBL_DEPTH];
    p = '0;
    if (cmd == CMD_RESTART) begin
      load_bin();
      return p;
    end
    a = (align_q == 0) ? 1 : align_q;
    w = round_up(pw, a);
    h = round_up(ph, a);
    found = 0; best_rot = 0; ovf = 0; best = 0; best_sc = 32'hFFFF_FFFF;
    for (int i = 0; i < free_cnt; i++) begin
      sr = short_side_left(free_tbl[i], w, h);
      st = short_side_left(free_tbl[i], h, w);
      if ((no_rot || sr <= st) && sr < best_sc) begin
        best = i; best_sc = sr; best_rot = 0; found = 1;
      end else if (!no_rot && st < best_sc) begin
        best = i; best_sc = st; best_rot = 1; found = 1;
      end
    end
    if (!found) return p;
    sel = free_tbl[best];
    bw = best_rot ? h : w;
    bh = best_rot ? w : h;
    pb.x0 = sel.x0; pb.y0 = sel.y0;
    pb.x1 = sel.x0 + bw - 1; pb.y1 = sel.y0 + bh - 1;
    for (int i = best; i + 1 < free_cnt; i++) free_tbl[i] = free_tbl[i+1];
    free_cnt--;
    if (bh < sel.y1 - sel.y0 + 1) begin
      r = sel; r.y0 = sel.y0 + bh;
      if (free_cnt < TBL_DEPTH) free_tbl[free_cnt++] = r; else ovf = 1;
    end
    if (bw < sel.x1 - sel.x0 + 1) begin
      r = sel; r.x0 = sel.x0 + bw;
      if (free_cnt < TBL_DEPTH) free_tbl[free_cnt++] = r; else ovf = 1;
    end
    n = 0;
    for (int i = 0; i < free_cnt; i++) begin
      f = free_tbl[i];
      if (!(pb.x1 >= f.x0 && f.x1 >= pb.x0 && pb.y1 >= f.y0 && f.y1 >= pb.y0))
        work[n++] = f;
    end
    for (int i = 0; i < free_cnt; i++) begin
      f = free_tbl[i];
      hit = pb.x1 >= f.x0 && f.x1 >= pb.x0 && pb.y1 >= f.y0 && f.y1 >= pb.y0;
      if (hit) begin
        if (f.x0 < pb.x0) begin
          r = f; r.x1 = pb.x0 - 1;
          if (n < TBL_DEPTH) work[n++] = r; else ovf = 1;
        end
        if (pb.x1 < f.x1) begin
          r = f; r.x0 = pb.x1 + 1;
          if (n < TBL_DEPTH) work[n++] = r; else ovf = 1;
        end
        if (f.y0 < pb.y0) begin
          r = f; r.y1 = pb.y0 - 1;
          if (n < TBL_DEPTH) work[n++] = r; else ovf = 1;
        end
        if (pb.y1 < f.y1) begin
          r = f; r.y0 = pb.y1 + 1;
          if (n < TBL_DEPTH) work[n++] = r; else ovf = 1;
        end
      end
    end
    // identical entries: the earlier one survives
    for (int i = 0; i < n; i++) begin
      drop[i] = 0;
      for (int j = 0; j < n; j++) begin
        if (i != j && !drop[i] && covered_by(work[i], work[j]) &&
            !(same_box(work[i], work[j]) && j > i))
          drop[i] = 1;
      end
    end
    free_cnt = 0;
    for (int i = 0; i < n; i++)
      if (!drop[i]) free_tbl[free_cnt++] = work[i];
    p.placed   = 1'b1;
    p.pos_x    = pb.x0[POS_W-1:0];
    p.pos_y    = pb.y0[POS_W-1:0];
    p.rotated  = best_rot;
    p.overflow = ovf;
    return p;
  endfunction

  task automatic send_patch(bit cmd, int unsigned pw, int unsigned ph, bit no_rot);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    item_ch.valid        <= 1'b1;
    item_ch.command      <= cmd;
    item_ch.patch_width  <= pw[FIELD_W-1:0];
    item_ch.patch_height <= ph[FIELD_W-1:0];
    item_ch.no_rotate    <= no_rot;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    expected_placements = {expected_placements,
                           pack_patch(cmd, pw[FIELD_W-1:0], ph[FIELD_W-1:0], no_rot)};
    item_ch.valid <= 1'b0;
    // the block is busy right after a transaction, so this costs no throughput
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_placements.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[FIELD_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_BIN_WIDTH:  bin_w = val & 14'h3FFF;
      CFG_BIN_HEIGHT: bin_h = val & 14'h3FFF;
      CFG_ALIGNMENT:  align_q = val & 7'h7F;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_bin(int unsigned w, int unsigned h, int unsigned a);
    drain();
    write_reg(CFG_BIN_WIDTH, w);
    write_reg(CFG_BIN_HEIGHT, h);
    write_reg(CFG_ALIGNMENT, a);
    send_patch(CMD_RESTART, $urandom_range(1, 8192), $urandom_range(1, 8192), $urandom_range(1));
  endtask

  task automatic test_directed();
    // reset-time table: whole 4096 bin, alignment 8
    send_patch(CMD_PLACE, 1, 1, 0);
    send_patch(CMD_PLACE, 8192, 8192, 0);      // no fit
    send_patch(CMD_PLACE, 0, 100, 0);          // zero side
    send_patch(CMD_PLACE, 4000, 100, 0);
    send_patch(CMD_PLACE, 100, 3000, 1);
    send_patch(CMD_PLACE, 100, 3000, 0);
    send_patch(CMD_RESTART, 0, 0, 0);
    set_bin(8192, 8192, 64);
    send_patch(CMD_PLACE, 8192, 8192, 0);      // whole bin
    send_patch(CMD_PLACE, 1, 1, 0);            // table empty
    send_patch(CMD_RESTART, 16383, 16383, 1);
    set_bin(16383, 1, 0);                      // saturation, zero alignment
    send_patch(CMD_PLACE, 1, 5, 0);            // fits only rotated
    send_patch(CMD_PLACE, 1, 5, 1);
    send_patch(CMD_PLACE, 16383, 1, 0);
    set_bin(0, 40, 1);                         // zero width acts as one
    send_patch(CMD_PLACE, 1, 40, 0);
    set_bin(64, 32, 127);
    send_patch(CMD_PLACE, 10, 10, 0);
  endtask

  task automatic test_random(int cnt);
    int unsigned g;
    for (int k = 0; k < cnt; k++) begin
      if ($urandom_range(29) == 0) begin
        send_patch(CMD_RESTART, $urandom_range(1, 16383), $urandom_range(1, 16383),
                   $urandom_range(1));
      end else begin
        g = (bin_w > 8 ? bin_w : 8);
        if ($urandom_range(9) == 0)
          send_patch(CMD_PLACE, $urandom_range(0, 16383), $urandom_range(0, 16383),
                     $urandom_range(1));
        else
          send_patch(CMD_PLACE, $urandom_range(1, g / 3 + 1), $urandom_range(1, g / 3 + 1),
                     $urandom_range(1));
      end
    end
  endtask

  task automatic test_fill_stall();
    // receiver holds off while items keep coming
    fork
      begin
        recv_hold = 1'b1;
        repeat (3000) @(posedge clk);
        recv_hold = 1'b0;
      end
      test_random(6);
    join
  endtask

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0; item_ch.command = 1'b0; item_ch.patch_width = '0;
    item_ch.patch_height = '0; item_ch.no_rotate = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_BIN_WIDTH; cfg_ch.data = '0;
    mismatches = 0; timeouts = 0; recv_hold = 1'b0;
    send_idle_pct = 14; recv_idle_pct = 65;
    bin_w = 4096; bin_h = 4096; align_q = 8;
    load_bin();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_bin(256, 192, 4);
    test_random(40);
    test_fill_stall();
    set_bin(1024, 512, 16);
    send_idle_pct = 65; recv_idle_pct = 14;
    test_random(40);
    set_bin(120, 90, 3);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(32);
    drain();
    if (mismatches == 0 && timeouts == 0) begin
      $display("maxrects_bssf_packer test passed");
    end else begin
      $display("maxrects_bssf_packer test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    placement_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = {res_ch.placed, res_ch.pos_x, res_ch.pos_y, res_ch.rotated, res_ch.overflow};
      if (expected_placements.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        want = expected_placements.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("maxrects_bssf_packer test failed");
        $finish;
      end
    end
  end

endmodule
